// ----- sv/irmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irmt_pkg
// Shared types and constants of the ID range map translator.
// ----------------------------------------------------------------------------
package irmt_pkg;

   localparam int MAP_ENTRIES_DEFAULT = 8;
   localparam int ID_W                = 32;
   localparam int SLOT_W              = 3;
   localparam int COUNT_W             = 4;
   localparam int CSR_INDEX_W         = 4;
   localparam int CSR_DATA_W          = 32;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_ENABLED = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 4'd1;

   typedef enum logic [1:0] {
      OP_LOAD           = 2'd0,
      OP_NS_TO_HOST     = 2'd1,
      OP_HOST_TO_NS     = 2'd2,
      OP_HOST_TO_NS_ROOT = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0] ns_base;
      logic [ID_W-1:0] host_base;
      logic [ID_W-1:0] length;
   } entry_type;

endpackage
`default_nettype wire

// ----- sv/irmt_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irmt channel interfaces
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface irmt_req_if;
   logic                              valid;
   logic                              ready;
   irmt_pkg::op_type                  operation;
   logic [irmt_pkg::SLOT_W-1:0]       entry_index;
   logic [irmt_pkg::ID_W-1:0]         entry_ns_base;
   logic [irmt_pkg::ID_W-1:0]         entry_host_base;
   logic [irmt_pkg::ID_W-1:0]         entry_length;
   logic [irmt_pkg::ID_W-1:0]         lookup_id;

   modport source (output valid, operation, entry_index, entry_ns_base,
                   entry_host_base, entry_length, lookup_id, input ready);
   modport sink   (input valid, operation, entry_index, entry_ns_base,
                   entry_host_base, entry_length, lookup_id, output ready);
endinterface

interface irmt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [irmt_pkg::ID_W-1:0] xlat_id;
   logic                      map_error;

   modport source (output valid, xlat_id, map_error, input ready);
   modport sink   (input valid, xlat_id, map_error, output ready);
endinterface

interface irmt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [irmt_pkg::CSR_INDEX_W-1:0] index;
   logic [irmt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/id_range_map_translator_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// id_range_map_translator_core
// Translates IDs between namespace and host through a table of ranges.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_if    in    valid/ready    operation, entry slot/bases/length, lookup_id
//  rsp_if    out   valid/ready    xlat_id, map_error
//  csr_if    in    valid/ready    index, data (always ready)
//
//  a load request gives no response
//  a lookup with the map disabled returns its ID unchanged; with the map
//  enabled the table is scanned one entry per cycle through its single read
//  port, then checked over two pipeline stages, stopping at the first hit;
//  a miss searches every entry up to the entry count, clipped to the table size
//  one request is worked at a time; the response sits in an output register,
//  so a new request is taken while a stalled response waits
//  reset is synchronous and clears the map registers and the control state
// ----------------------------------------------------------------------------
module id_range_map_translator_core #(
   parameter int MAP_ENTRIES = irmt_pkg::MAP_ENTRIES_DEFAULT
) (
   input wire logic clock,
   input wire logic reset,
   irmt_req_if.sink   req_if,
   irmt_rsp_if.source rsp_if,
   irmt_csr_if.sink   csr_if
);

   localparam int ADDR_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
   localparam int CNT_W  = $clog2(MAP_ENTRIES + 1);
   localparam int ID_W   = irmt_pkg::ID_W;

   // configuration
   logic                          map_enabled_ff;
   logic [irmt_pkg::COUNT_W-1:0]  entry_count_ff;

   // request context
   irmt_pkg::state_type  state_ff, state_in;
   irmt_pkg::op_type     op_ff, op_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     idx_ff, idx_in;
   logic                 zero_seen_ff, zero_seen_in;

   // scan pipeline
   logic                 rd_vld_ff, rd_vld_in;
   logic                 s1_vld_ff, s1_vld_in;
   logic [ID_W-1:0]      s1_diff_ff, s1_diff_in;
   logic                 s1_ge_ff, s1_ge_in;
   logic [ID_W-1:0]      s1_to_ff, s1_to_in;
   logic [ID_W-1:0]      s1_len_ff, s1_len_in;

   // result and output register
   logic [ID_W-1:0]      res_ff, res_in;
   logic                 res_err_ff, res_err_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic [ID_W-1:0]      rsp_id_ff, rsp_id_in;
   logic                 rsp_err_ff, rsp_err_in;

   // table ports
   logic                 tbl_we;
   logic [ADDR_W-1:0]    tbl_waddr;
   irmt_pkg::entry_type  tbl_wdata;
   logic                 tbl_re;
   logic [ADDR_W-1:0]    tbl_raddr;
   irmt_pkg::entry_type  tbl_rdata;

   logic                 req_fire;
   logic                 rsp_free;
   logic                 slot_ok;
   logic [CNT_W-1:0]     searched;
   logic                 dir_to_host;
   logic [ID_W-1:0]      from_base;
   logic [ID_W-1:0]      to_base;
   logic [ID_W:0]        diff_wide;
   logic [ID_W:0]        sum_wide;
   logic                 hit;
   logic                 scan_end;

   irmt_table #(
      .MAP_ENTRIES(MAP_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_en   (tbl_re),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   // configuration writes
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_enabled_ff <= 1'b0;
         entry_count_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            irmt_pkg::CSR_MAP_ENABLED: map_enabled_ff <= csr_if.data[0];
            irmt_pkg::CSR_ENTRY_COUNT: entry_count_ff <= csr_if.data[irmt_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_if.ready = (state_ff == irmt_pkg::ST_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_vld_ff || rsp_if.ready;

   assign slot_ok  = (32'(req_if.entry_index) < 32'(MAP_ENTRIES));
   assign searched = (32'(entry_count_ff) > 32'(MAP_ENTRIES)) ?
                     CNT_W'(MAP_ENTRIES) : CNT_W'(entry_count_ff);

   assign tbl_waddr = ADDR_W'(req_if.entry_index);
   assign tbl_wdata = '{ns_base:   req_if.entry_ns_base,
                        host_base: req_if.entry_host_base,
                        length:    req_if.entry_length};
   assign tbl_raddr = idx_ff[ADDR_W-1:0];

   // stage 1: offset of the id within the range read last cycle
   assign dir_to_host = (op_ff == irmt_pkg::OP_NS_TO_HOST);
   assign from_base   = dir_to_host ? tbl_rdata.ns_base : tbl_rdata.host_base;
   assign to_base     = dir_to_host ? tbl_rdata.host_base : tbl_rdata.ns_base;
   assign diff_wide   = {1'b0, id_ff} - {1'b0, from_base};

   // stage 2: containment and translated sum
   assign sum_wide = {1'b0, s1_to_ff} + {1'b0, s1_diff_ff};
   assign hit      = s1_vld_ff && s1_ge_ff && (s1_diff_ff < s1_len_ff);
   assign scan_end = (idx_ff == cnt_ff) && !rd_vld_ff && !s1_vld_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      zero_seen_in = zero_seen_ff;
      rd_vld_in    = 1'b0;
      s1_vld_in    = 1'b0;
      s1_diff_in   = s1_diff_ff;
      s1_ge_in     = s1_ge_ff;
      s1_to_in     = s1_to_ff;
      s1_len_in    = s1_len_ff;
      res_in       = res_ff;
      res_err_in   = res_err_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_if.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_err_in   = rsp_err_ff;
      tbl_we       = 1'b0;
      tbl_re       = 1'b0;

      case (state_ff)
         irmt_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in        = req_if.operation;
               id_in        = req_if.lookup_id;
               cnt_in       = searched;
               idx_in       = '0;
               zero_seen_in = 1'b0;
               if (req_if.operation == irmt_pkg::OP_LOAD) begin
                  tbl_we = slot_ok;
               end else if (!map_enabled_ff) begin
                  res_in     = req_if.lookup_id;
                  res_err_in = 1'b0;
                  state_in   = irmt_pkg::ST_DONE;
               end else begin
                  state_in = irmt_pkg::ST_SCAN;
               end
            end
         end
         irmt_pkg::ST_SCAN: begin
            if (idx_ff < cnt_ff) begin
               tbl_re    = 1'b1;
               rd_vld_in = 1'b1;
               idx_in    = idx_ff + CNT_W'(1);
            end
            if (rd_vld_ff) begin
               s1_vld_in    = 1'b1;
               s1_diff_in   = diff_wide[ID_W-1:0];
               s1_ge_in     = !diff_wide[ID_W];
               s1_to_in     = to_base;
               s1_len_in    = tbl_rdata.length;
               zero_seen_in = zero_seen_ff || (tbl_rdata.ns_base == '0);
            end
            if (hit) begin
               // first hit wins, an overflowing sum is an error
               res_in     = sum_wide[ID_W-1:0];
               res_err_in = sum_wide[ID_W];
               state_in   = irmt_pkg::ST_DONE;
            end else if (scan_end) begin
               // root fallback: host 0 maps to namespace 0 if some searched range starts at 0
               res_in     = '0;
               res_err_in = !((op_ff == irmt_pkg::OP_HOST_TO_NS_ROOT) &&
                              (id_ff == '0) && zero_seen_ff);
               state_in   = irmt_pkg::ST_DONE;
            end
         end
         irmt_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_vld_in = 1'b1;
               rsp_id_in  = res_err_ff ? '0 : res_ff;
               rsp_err_in = res_err_ff;
               state_in   = irmt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = irmt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= irmt_pkg::ST_IDLE;
         rd_vld_ff  <= 1'b0;
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_vld_ff  <= rd_vld_in;
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      id_ff        <= id_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      zero_seen_ff <= zero_seen_in;
      s1_diff_ff   <= s1_diff_in;
      s1_ge_ff     <= s1_ge_in;
      s1_to_ff     <= s1_to_in;
      s1_len_ff    <= s1_len_in;
      res_ff       <= res_in;
      res_err_ff   <= res_err_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.xlat_id   = rsp_id_ff;
   assign rsp_if.map_error = rsp_err_ff;

endmodule
`default_nettype wire

// ----- sv/irmt_table.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// irmt_table
// Range entry memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module irmt_table #(
   parameter int MAP_ENTRIES = irmt_pkg::MAP_ENTRIES_DEFAULT,
   localparam int ADDR_W = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [ADDR_W-1:0]   wr_addr,
   input  wire irmt_pkg::entry_type wr_data,
   input  wire logic                rd_en,
   input  wire logic [ADDR_W-1:0]   rd_addr,
   output irmt_pkg::entry_type      rd_data
);

   irmt_pkg::entry_type mem [MAP_ENTRIES];
   irmt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- tb/id_range_map_translator_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id_range_map_translator_core_test
// Self-checking bench for the ID range map translator. Requests are driven
// on the falling edge and every response is checked against a predictor
// that keeps its own copy of the range table and the map registers.
// ----------------------------------------------------------------------------
module id_range_map_translator_core_test;

   localparam int SLOTS         = irmt_pkg::MAP_ENTRIES_DEFAULT;
   localparam int ID_W          = irmt_pkg::ID_W;
   localparam int SLOT_W        = irmt_pkg::SLOT_W;
   localparam int COUNT_W       = irmt_pkg::COUNT_W;
   localparam int CSR_INDEX_W   = irmt_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W    = irmt_pkg::CSR_DATA_W;
   localparam int SETTLE_CYCLES = 24;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 80;

   typedef struct packed {
      logic [ID_W-1:0] xlat_id;
      logic            map_error;
   } xlat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   irmt_req_if req_if();
   irmt_rsp_if rsp_if();
   irmt_csr_if csr_if();

   id_range_map_translator_core #(.MAP_ENTRIES(SLOTS)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // predictor copy of the table and registers
   logic [ID_W-1:0]    ns_tab[SLOTS];
   logic [ID_W-1:0]    host_tab[SLOTS];
   logic [ID_W-1:0]    len_tab[SLOTS];
   logic               map_on       = 1'b0;
   logic [COUNT_W-1:0] search_count = '0;

   xlat_result_type pending_results[$];

   bit quiet      = 1'b0;
   int hold_count = 0;
   int burst_left = 0;
   int mismatches = 0;
   int loads_sent = 0;
   int lookups_sent = 0;
   int errors_seen = 0;
   int settings_used = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("CHECK FAILED");
      $finish;
   end

   function automatic xlat_result_type translate_id(irmt_pkg::op_type op,
                                                    logic [ID_W-1:0] id);
      xlat_result_type r;
      int              n;
      bit              hit;
      logic [ID_W-1:0] from;
      logic [ID_W-1:0] to;
      logic [ID_W:0]   sum;
      r.xlat_id   = '0;
      r.map_error = 1'b1;
      hit = 1'b0;
      if (!map_on) begin
         r.xlat_id   = id;
         r.map_error = 1'b0;
         return r;
      end
      n = (search_count > SLOTS) ? SLOTS : search_count;
      for (int i = 0; i < n; i++) begin
         from = (op == irmt_pkg::OP_NS_TO_HOST) ? ns_tab[i] : host_tab[i];
         to   = (op == irmt_pkg::OP_NS_TO_HOST) ? host_tab[i] : ns_tab[i];
         // first containing range decides, even when its sum overflows
         if (!hit && id >= from && (id - from) < len_tab[i]) begin
            hit = 1'b1;
            sum = {1'b0, to} + {1'b0, id - from};
            if (!sum[ID_W]) begin
               r.xlat_id   = sum[ID_W-1:0];
               r.map_error = 1'b0;
            end
         end
      end
      // host 0 falls back to namespace 0 if any searched range starts at 0
      if (r.map_error && op == irmt_pkg::OP_HOST_TO_NS_ROOT && id == '0) begin
         for (int i = 0; i < n; i++) begin
            if (ns_tab[i] == '0) r.map_error = 1'b0;
         end
      end
      if (r.map_error) r.xlat_id = '0;
      return r;
   endfunction

   function automatic logic [ID_W-1:0] pick_base();
      case ($urandom_range(0, 9))
         0:       return '0;
         1, 2:    return $urandom_range(0, 255);
         3:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [ID_W-1:0] pick_length();
      case ($urandom_range(0, 9))
         0:          return '0;
         1:          return 32'hFFFF_FFFF;
         2, 3, 4:    return $urandom_range(1, 4096);
         5, 6:       return $urandom_range(1, 1 << 20);
         default:    return $urandom;
      endcase
   endfunction

   // mostly lands inside a loaded range, sometimes on its edges or anywhere
   function automatic logic [ID_W-1:0] pick_lookup_id(irmt_pkg::op_type op);
      int              s;
      logic [ID_W-1:0] from;
      logic [ID_W-1:0] len;
      s    = $urandom_range(0, SLOTS - 1);
      from = (op == irmt_pkg::OP_NS_TO_HOST) ? ns_tab[s] : host_tab[s];
      len  = len_tab[s];
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return from + len;
         2:       return from + len - 1;
         3:       return $urandom;
         4:       return 32'hFFFF_FFFF;
         default: return (len == '0) ? from : from + $urandom_range(0, len - 1);
      endcase
   endfunction

   task automatic send_request(irmt_pkg::op_type op, logic [SLOT_W-1:0] slot,
                               logic [ID_W-1:0] ns_base, logic [ID_W-1:0] host_base,
                               logic [ID_W-1:0] length, logic [ID_W-1:0] id);
      int gap;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         @(negedge clock);
         req_if.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.operation       = op;
      req_if.entry_index     = slot;
      req_if.entry_ns_base   = ns_base;
      req_if.entry_host_base = host_base;
      req_if.entry_length    = length;
      req_if.lookup_id       = id;
      req_if.valid           = 1'b1;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (op == irmt_pkg::OP_LOAD) begin
         ns_tab[slot]   = ns_base;
         host_tab[slot] = host_base;
         len_tab[slot]  = length;
         loads_sent++;
      end else begin
         pending_results.push_back(translate_id(op, id));
         lookups_sent++;
      end
   endtask

   task automatic send_load(logic [SLOT_W-1:0] slot, logic [ID_W-1:0] ns_base,
                            logic [ID_W-1:0] host_base, logic [ID_W-1:0] length);
      send_request(irmt_pkg::OP_LOAD, slot, ns_base, host_base, length, $urandom);
   endtask

   task automatic send_lookup(irmt_pkg::op_type op, logic [ID_W-1:0] id);
      send_request(op, SLOT_W'($urandom), $urandom, $urandom, $urandom, id);
   endtask

   // loads give no response, so let the block settle past the last one too
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_if.index = index;
      csr_if.data  = value;
      csr_if.valid = 1'b1;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (index)
         irmt_pkg::CSR_MAP_ENABLED: map_on = value[0];
         irmt_pkg::CSR_ENTRY_COUNT: search_count = value[COUNT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic set_map(bit enabled, int count);
      write_csr(irmt_pkg::CSR_MAP_ENABLED, CSR_DATA_W'(enabled));
      write_csr(irmt_pkg::CSR_ENTRY_COUNT, CSR_DATA_W'(count));
      settings_used++;
   endtask

   task automatic test_load_and_pass_through();
      // overlapping, empty, overflowing and top-of-range entries
      send_load(3'd0, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
      send_load(3'd1, 32'h0000_8000, 32'h0020_0000, 32'h0000_0100);
      send_load(3'd2, 32'h0010_0000, 32'hFFFF_FF00, 32'h0000_0200);
      send_load(3'd3, 32'hFFFF_FFF0, 32'h0030_0000, 32'h0000_0010);
      send_load(3'd4, 32'h0040_0000, 32'h0040_0000, 32'h0000_0000);
      send_load(3'd5, 32'h0050_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_load(3'd6, 32'h7000_0000, 32'h8000_0000, 32'h1000_0000);
      send_load(3'd7, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0001);
      // map disabled out of reset: IDs come back unchanged
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'h0000_0000);
      send_lookup(irmt_pkg::OP_HOST_TO_NS, 32'hFFFF_FFFF);
      send_lookup(irmt_pkg::OP_HOST_TO_NS_ROOT, $urandom);
   endtask

   task automatic test_directed_map();
      set_map(1'b1, SLOTS);
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'h0000_0000);
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'h0000_8010);      // first of two overlaps wins
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'h0001_0000);      // one past the end
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'h0010_01FF);      // sum above 32 bits
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'hFFFF_FFFF);
      send_lookup(irmt_pkg::OP_HOST_TO_NS, 32'hFFFF_FFFF);
      send_lookup(irmt_pkg::OP_HOST_TO_NS, 32'h0000_0001);
      send_lookup(irmt_pkg::OP_HOST_TO_NS, 32'h0000_0000);      // strict miss on host 0
      send_lookup(irmt_pkg::OP_HOST_TO_NS_ROOT, 32'h0000_0000); // root fallback
      send_lookup(irmt_pkg::OP_HOST_TO_NS_ROOT, 32'h0001_001F);
      send_lookup(irmt_pkg::OP_HOST_TO_NS_ROOT, 32'h0000_0005);
      set_map(1'b1, 1);
      send_lookup(irmt_pkg::OP_HOST_TO_NS_ROOT, 32'h0000_0000);
      set_map(1'b1, 0);                                         // empty map misses everything
      send_lookup(irmt_pkg::OP_HOST_TO_NS_ROOT, 32'h0000_0000);
      send_lookup(irmt_pkg::OP_NS_TO_HOST, 32'h0000_0000);
      set_map(1'b1, 15);                                        // count clipped to the table size
      send_lookup(irmt_pkg::OP_HOST_TO_NS, 32'h0000_0001);
   endtask

   task automatic test_response_backpressure();
      irmt_pkg::op_type op;
      set_map(1'b1, SLOTS);
      @(posedge clock);
      quiet = 1'b1;
      hold_count = HOLD_CYCLES;
      repeat (16) begin
         op = irmt_pkg::op_type'($urandom_range(1, 3));
         send_lookup(op, pick_lookup_id(op));
      end
      quiet = 1'b0;
   endtask

   task automatic run_random_phase(bit enabled, int count, int items);
      irmt_pkg::op_type  op;
      logic [SLOT_W-1:0] slot;
      set_map(enabled, count);
      repeat (items) begin
         if ($urandom_range(0, 7) == 0) begin
            slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            send_load(slot, pick_base(), pick_base(), pick_length());
         end else begin
            op = irmt_pkg::op_type'($urandom_range(1, 3));
            send_lookup(op, pick_lookup_id(op));
         end
      end
   endtask

   task automatic test_random_traffic();
      run_random_phase(1'b1, SLOTS, PHASE_ITEMS);
      run_random_phase(1'b1, 3, PHASE_ITEMS);
      run_random_phase(1'b0, 6, PHASE_ITEMS);
      run_random_phase(1'b1, 15, PHASE_ITEMS);
      run_random_phase(1'b1, 1, PHASE_ITEMS);
      run_random_phase(1'b1, 0, 40);
      run_random_phase(1'b1, 5, PHASE_ITEMS);
      quiet = 1'b1;
      run_random_phase(1'b1, SLOTS, PHASE_ITEMS);
   endtask

   // response side: random stall bursts plus the long hold
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_count > 0) begin
            rsp_if.ready = 1'b0;
            hold_count--;
         end else if (burst_left > 0) begin
            rsp_if.ready = 1'b0;
            burst_left--;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_if.ready = 1'b0;
            burst_left = $urandom_range(1, 14) - 1;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      xlat_result_type exp_res;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: id %h err %b",
                        rsp_if.xlat_id, rsp_if.map_error);
            mismatches++;
         end else begin
            exp_res = pending_results.pop_front();
            if (rsp_if.map_error === 1'b1) errors_seen++;
            if (rsp_if.xlat_id !== exp_res.xlat_id ||
                rsp_if.map_error !== exp_res.map_error) begin
               if (mismatches < 10)
                  $display("mismatch: expected id %h err %b, got id %h err %b",
                           exp_res.xlat_id, exp_res.map_error,
                           rsp_if.xlat_id, rsp_if.map_error);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_if.valid           = 1'b0;
      req_if.operation       = irmt_pkg::OP_LOAD;
      req_if.entry_index     = '0;
      req_if.entry_ns_base   = '0;
      req_if.entry_host_base = '0;
      req_if.entry_length    = '0;
      req_if.lookup_id       = '0;
      csr_if.valid           = 1'b0;
      csr_if.index           = irmt_pkg::CSR_MAP_ENABLED;
      csr_if.data            = '0;
      for (int i = 0; i < SLOTS; i++) begin
         ns_tab[i]   = '0;
         host_tab[i] = '0;
         len_tab[i]  = '0;
      end
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_and_pass_through();
      test_directed_map();
      test_response_backpressure();
      test_random_traffic();
      wait_idle();

      $display("ran %0d table loads and %0d lookups over %0d map settings",
               loads_sent, lookups_sent, settings_used);
      $display("%0d lookups flagged an error; one long response stall included",
               errors_seen);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/irmt_pkg.sv
sv/irmt_if.sv
sv/irmt_table.sv
sv/id_range_map_translator_core.sv
tb/id_range_map_translator_core_test.sv
